// ===== rtl/core/mtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_pkg
// Types, character codes and the successor tree ROM shared by the decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int NODE_W      = 5;
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [NODE_W-1:0] ROOT_NODE = 5'd0;
    localparam logic [NODE_W-1:0] SINK_NODE = 5'd27;

    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd64;
    localparam logic [CHAR_W-1:0] CHR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHR_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CHR_QMARK   = 8'h3F;
    localparam logic [CHAR_W-1:0] CHR_CLEAR   = 8'h43;
    localparam logic [CHAR_W-1:0] CHR_APOS    = 8'h27;
    localparam logic [CHAR_W-1:0] CHR_DQUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_NONE    = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_PREVIEW = 2'd0,
        KIND_COMMIT  = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [KIND_W-1:0] kind;
        logic              last;
    } res_t;

    // one decode step: a push flag plus up to two results
    typedef struct packed {
        logic              push;
        logic              two;
        res_t              r0;
        res_t              r1;
    } step_t;

    // {dot successor, dash successor}
    function automatic logic [2*NODE_W-1:0] mtd_succ_pair(input logic [NODE_W-1:0] node);
        logic [2*NODE_W-1:0] pair;
        begin
            case (node)
                5'd0:    pair = {5'd5,  5'd20};
                5'd1:    pair = {5'd18, 5'd23};
                5'd4:    pair = {5'd2,  5'd24};
                5'd5:    pair = {5'd9,  5'd1};
                5'd7:    pair = {5'd26, 5'd17};
                5'd9:    pair = {5'd19, 5'd21};
                5'd11:   pair = {5'd3,  5'd25};
                5'd13:   pair = {5'd7,  5'd15};
                5'd14:   pair = {5'd4,  5'd11};
                5'd18:   pair = {5'd12, 5'd27};
                5'd19:   pair = {5'd8,  5'd22};
                5'd20:   pair = {5'd14, 5'd13};
                5'd21:   pair = {5'd6,  5'd27};
                5'd23:   pair = {5'd16, 5'd10};
                default: pair = {SINK_NODE, SINK_NODE};
            endcase
            return pair;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] mtd_pending(input logic [NODE_W-1:0] node);
        logic [CHAR_W-1:0] ch;
        begin
            if (node == ROOT_NODE)
                ch = CHR_BANG;
            else if (node >= SINK_NODE)
                ch = CHR_QMARK;
            else
                ch = LETTER_BASE + {{(CHAR_W-NODE_W){1'b0}}, node};
            return ch;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mtd_sym_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_sym_if
// Valid/ready channel carrying one Morse symbol byte per transaction.
// ----------------------------------------------------------------------------
interface mtd_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtd_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_res_if
// Valid/ready channel carrying one decoded result per transaction.
// ----------------------------------------------------------------------------
interface mtd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output character, output kind, output last, input ready);
    modport sink   (input valid, input character, input kind, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_step
// Decode one symbol against the current node: results and next node.
// ----------------------------------------------------------------------------
module mtd_step (
    input  wire logic [7:0]          symbol,
    input  wire logic [4:0]          node,
    output      mtd_pkg::step_t      step,
    output      logic [4:0]          node_next
);
    import mtd_pkg::*;

    logic [2*NODE_W-1:0] pair;

    assign pair = mtd_succ_pair(node);

    always_comb
    begin
        step           = '0;
        step.push      = 1'b1;
        step.r0.last   = 1'b1;
        step.r0.kind   = KIND_PREVIEW;
        node_next      = ROOT_NODE;
        case (symbol)
            CHR_CLEAR:
            begin
                step.r0.character = CHR_NONE;
                step.r0.kind      = KIND_CLEAR;
            end
            CHR_APOS:
            begin
                step.r0.character = mtd_pending(node);
                step.r0.kind      = KIND_COMMIT;
            end
            CHR_DQUOTE:
            begin
                step.two          = 1'b1;
                step.r0.character = mtd_pending(node);
                step.r0.kind      = KIND_COMMIT;
                step.r0.last      = 1'b0;
                step.r1.character = CHR_SPACE;
                step.r1.kind      = KIND_COMMIT;
                step.r1.last      = 1'b1;
            end
            CHR_DOT:
            begin
                node_next         = pair[2*NODE_W-1:NODE_W];
                step.r0.character = mtd_pending(pair[2*NODE_W-1:NODE_W]);
            end
            CHR_DASH:
            begin
                node_next         = pair[NODE_W-1:0];
                step.r0.character = mtd_pending(pair[NODE_W-1:0]);
            end
            default:
            begin
                node_next         = SINK_NODE;
                step.r0.character = CHR_QMARK;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/mtd_res_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_res_queue
// Small result queue: takes one or two results per cycle, gives one.
// ----------------------------------------------------------------------------
module mtd_res_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mtd_pkg::step_t step,
    output      logic           room,
    output      logic           head_valid,
    output      mtd_pkg::res_t  head,
    input  wire logic           pop
);
    import mtd_pkg::*;

    res_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;
    logic [QPTR_W-1:0] wr_ptr_inc;

    // two free entries needed, regardless of this cycle's pop
    assign room       = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop & head_valid;
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (step.push)
            wr_ptr_next = step.two ? (wr_ptr_reg + QPTR_W'(2)) : wr_ptr_inc;
        rd_ptr_next = do_pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg
                    + QCNT_W'(step.push)
                    + QCNT_W'(step.push & step.two)
                    - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.push)
        begin
            mem[wr_ptr_reg] <= step.r0;
            if (step.two)
                mem[wr_ptr_inc] <= step.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/morse_tree_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_tree_decoder_core
// Morse decoder walking a 28-node (dot, dash) successor tree.
// ----------------------------------------------------------------------------
// Usage:
//   symbols : sink channel, one ASCII symbol byte per transaction
//             ('.', '-', apostrophe, double quote, 'C'; anything else is an
//             error symbol that drops the walk into the sink node).
//   results : source channel, one result per transaction (character, kind,
//             last). A double quote yields two results, everything else one.
//   Output  : results are offered from the registered result queue, oldest first.
//   Throughput: one symbol per cycle while the queue has room; a double
//             quote's two results leave one at a time by the queue's read port.
//   Stalls  : results wait in a 4-entry queue. symbols.ready stays high
//             while at least two entries are free, so the input keeps moving
//             while a result waits to be taken.
//   Reset   : node returns to the root (pending character '!') and the
//             queue empties.
// ----------------------------------------------------------------------------
module morse_tree_decoder_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mtd_sym_if.sink   symbols,
    mtd_res_if.source results
);
    import mtd_pkg::*;

    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] node_next;
    logic [NODE_W-1:0] node_step;
    step_t             step_raw;
    step_t             step;
    logic              room;
    logic              accept;
    res_t              head;

    assign symbols.ready = room;
    assign accept        = symbols.valid & room;

    // tree lookup on the incoming symbol against the current node
    mtd_step u_step (
        .symbol    (symbols.symbol),
        .node      (node_reg),
        .step      (step_raw),
        .node_next (node_step)
    );

    // only an accepted transaction pushes results
    always_comb
    begin
        step      = step_raw;
        step.push = accept;
        node_next = accept ? node_step : node_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_reg <= ROOT_NODE;
        else
            node_reg <= node_next;
    end

    // result register stage / skid queue
    mtd_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .room       (room),
        .head_valid (results.valid),
        .head       (head),
        .pop        (results.ready)
    );

    assign results.character = head.character;
    assign results.kind      = head.kind;
    assign results.last      = head.last;

endmodule
`default_nettype wire

// ===== rtl/core/mtd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mtd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_character,
    input wire logic [1:0] out_kind,
    input wire logic       out_last
);
    import mtd_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == KIND_PREVIEW || out_kind == KIND_COMMIT
                       || out_kind == KIND_CLEAR))
        else $error("illegal result kind");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CLEAR |-> out_character == CHR_NONE && out_last)
        else $error("clear result malformed");

    a_notlast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_kind == KIND_COMMIT)
        else $error("non-final result that is not a commit");

    // a first commit of a pair is followed at once by the space
    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && out_character == CHR_SPACE && out_kind == KIND_COMMIT && out_last)
        else $error("space missing after double-quote commit");

endmodule

bind morse_tree_decoder_core mtd_checker u_mtd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_character (results.character),
    .out_kind      (results.kind),
    .out_last      (results.last)
);
`default_nettype wire

// ===== verif/mtd_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_decoder_checker
// Watches the symbol and result channels of the Morse tree decoder, keeps its
// own copy of the tree walk, and compares every result transaction against
// the oldest predicted one.
// ----------------------------------------------------------------------------
module mtd_decoder_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    mtd_sym_if        sym_tap,
    mtd_res_if        res_tap,
    output int        fail_count,
    output int        outstanding
);
    import mtd_pkg::*;

    logic [NODE_W-1:0] walk_node;
    res_t              owed_results [$];

    // dash = 0 takes the dot branch
    function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] node,
                                                    input logic dash);
        logic [NODE_W-1:0] nxt;
        nxt = SINK_NODE;
        case (node)
            5'd0:  nxt = dash ? 5'd20 : 5'd5;
            5'd1:  nxt = dash ? 5'd23 : 5'd18;
            5'd4:  nxt = dash ? 5'd24 : 5'd2;
            5'd5:  nxt = dash ? 5'd1  : 5'd9;
            5'd7:  nxt = dash ? 5'd17 : 5'd26;
            5'd9:  nxt = dash ? 5'd21 : 5'd19;
            5'd11: nxt = dash ? 5'd25 : 5'd3;
            5'd13: nxt = dash ? 5'd15 : 5'd7;
            5'd14: nxt = dash ? 5'd11 : 5'd4;
            5'd18: nxt = dash ? SINK_NODE : 5'd12;
            5'd19: nxt = dash ? 5'd22 : 5'd8;
            5'd20: nxt = dash ? 5'd13 : 5'd14;
            5'd21: nxt = dash ? SINK_NODE : 5'd6;
            5'd23: nxt = dash ? 5'd10 : 5'd16;
            default: nxt = SINK_NODE;    // leaves, sink and unused codes
        endcase
        return nxt;
    endfunction

    function automatic logic [CHAR_W-1:0] shown_char(input logic [NODE_W-1:0] node);
        logic [CHAR_W-1:0] ch;
        if (node == ROOT_NODE)
            ch = CHR_BANG;
        else if (node >= SINK_NODE)
            ch = CHR_QMARK;
        else
            ch = LETTER_BASE + CHAR_W'(node);
        return ch;
    endfunction

    task automatic owe(input logic [CHAR_W-1:0] ch, input kind_t kd, input logic fin);
        res_t r;
        r.character = ch;
        r.kind      = kd;
        r.last      = fin;
        owed_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            walk_node = ROOT_NODE;
            owed_results.delete();
            fail_count = 0;
        end
        else
        begin
            // predict first so a same-edge result would still find its entry
            if (sym_tap.valid && sym_tap.ready)
            begin
                case (sym_tap.symbol)
                    CHR_CLEAR:
                    begin
                        owe(CHR_NONE, KIND_CLEAR, 1'b1);
                        walk_node = ROOT_NODE;
                    end
                    CHR_APOS:
                    begin
                        owe(shown_char(walk_node), KIND_COMMIT, 1'b1);
                        walk_node = ROOT_NODE;
                    end
                    CHR_DQUOTE:
                    begin
                        owe(shown_char(walk_node), KIND_COMMIT, 1'b0);
                        owe(CHR_SPACE, KIND_COMMIT, 1'b1);
                        walk_node = ROOT_NODE;
                    end
                    CHR_DOT:
                    begin
                        walk_node = next_node(walk_node, 1'b0);
                        owe(shown_char(walk_node), KIND_PREVIEW, 1'b1);
                    end
                    CHR_DASH:
                    begin
                        walk_node = next_node(walk_node, 1'b1);
                        owe(shown_char(walk_node), KIND_PREVIEW, 1'b1);
                    end
                    default:
                    begin
                        walk_node = SINK_NODE;
                        owe(shown_char(walk_node), KIND_PREVIEW, 1'b1);
                    end
                endcase
            end

            if (res_tap.valid && res_tap.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual char=%h kind=%0d last=%0d",
                             $time, res_tap.character, res_tap.kind, res_tap.last);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res_tap.character !== want.character)
                    begin
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.character, res_tap.character);
                        fail_count++;
                    end
                    if (res_tap.kind !== want.kind)
                    begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, want.kind, res_tap.kind);
                        fail_count++;
                    end
                    if (res_tap.last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, want.last, res_tap.last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

// ===== verif/tb_morse_tree_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_tree_decoder_core
// Drives Morse symbol bytes into the decoder core under random source gaps and
// sink stalls; a checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_morse_tree_decoder_core;
    import mtd_pkg::*;

    // Run shape. The tail of the run drops all idling on both sides.
    localparam int TOTAL_ITEMS    = 1850;
    localparam int CALM_TAIL      = 200;
    // Slowest legal run still moves something after each source gap and sink
    // stall, so reaching WATCHDOG_LIMIT quiet cycles means the block is stuck.
    localparam int WATCHDOG_LIMIT = 1000;
    // Spare cycles let a stray extra result surface before the verdict.
    localparam int DRAIN_CYCLES   = 8;

    logic clk;
    logic rst_n;
    int   fails;
    int   owed_cnt;
    int   sent;
    bit   calm;         // set once the run enters its idle-free tail

    mtd_sym_if sym_ch ();
    mtd_res_if res_ch ();

    morse_tree_decoder_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_ch),
        .results (res_ch)
    );

    // Checker only observes both channels; it owns prediction and compare.
    mtd_decoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_tap     (sym_ch),
        .res_tap     (res_ch),
        .fail_count  (fails),
        .outstanding (owed_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one symbol and hold it until the block takes it. Drive changes
    // happen at the falling edge; the handshake is judged on pre-edge values
    // at the rising edge. Valid stays high between back-to-back transactions.
    task automatic send_symbol(input logic [7:0] sym);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            sym_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sym_ch.valid  = 1'b1;
        sym_ch.symbol = sym;
        @(posedge clk);
        while (!sym_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        calm = (sent >= TOTAL_ITEMS - CALM_TAIL);
    endtask

    // Result sink: ready drops in random bursts, except in the tail.
    initial
    begin
        int   hold;
        logic rdy;
        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rdy = 1'b0;
                hold--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rdy  = 1'b0;
                hold = $urandom_range(0, 2);
            end
            else
                rdy = 1'b1;
            res_ch.ready = rdy;
        end
    end

    // Watchdog: any accepted transaction on either side resets the count.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results still owed", $time, owed_cnt);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        int         walk_len;
        int         pick;
        logic [7:0] noise;
        // Opening directed set:
        //  - commit and double-quote commit straight out of reset (empty '!')
        //  - single dot / dash previews and their commits (E, T, A)
        //  - clear after a partial walk and clear at the root
        //  - error bytes at both ends of the byte range, lowercase c, and a
        //    dot taken while parked in the error sink
        //  - deepest walk to Z, and a dot run that falls off a leaf
        logic [7:0] opening [$] = '{
            CHR_APOS, CHR_DQUOTE,
            CHR_DOT, CHR_APOS,
            CHR_DASH, CHR_DQUOTE,
            CHR_DOT, CHR_DASH, CHR_APOS,
            CHR_DOT, CHR_CLEAR, CHR_CLEAR,
            8'h00, CHR_DOT, CHR_APOS,
            8'hFF, CHR_DQUOTE,
            8'h63, CHR_CLEAR,
            CHR_DASH, CHR_DASH, CHR_DOT, CHR_DOT, CHR_DQUOTE,
            CHR_DOT, CHR_DOT, CHR_DOT, CHR_DOT, CHR_DOT, CHR_APOS
        };

        rst_n         = 1'b0;
        sym_ch.valid  = 1'b0;
        sym_ch.symbol = 8'h00;
        sent          = 0;
        calm          = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_symbol(opening[i]);

        // Random part. Mostly well-formed letters: 0..5 random dots/dashes
        // (depth 5 runs past every leaf into the sink), the odd error byte
        // mixed in, then a separator or a clear. The rest is raw byte noise,
        // which also covers every bit of the symbol field both ways.
        while (sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                walk_len = $urandom_range(0, 5);
                repeat (walk_len)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        noise = 8'($urandom_range(0, 255));
                        send_symbol(noise);
                    end
                    else
                        send_symbol($urandom_range(0, 1) ? CHR_DASH : CHR_DOT);
                end
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    send_symbol(CHR_APOS);
                else if (pick < 16)
                    send_symbol(CHR_DQUOTE);
                else
                    send_symbol(CHR_CLEAR);
            end
            else
            begin
                walk_len = $urandom_range(1, 3);
                repeat (walk_len)
                begin
                    noise = 8'($urandom_range(0, 255));
                    send_symbol(noise);
                end
            end
        end
        sym_ch.valid = 1'b0;

        wait (owed_cnt == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mtd_pkg.sv
rtl/core/mtd_sym_if.sv
rtl/core/mtd_res_if.sv
rtl/core/mtd_step.sv
rtl/core/mtd_res_queue.sv
rtl/core/morse_tree_decoder_core.sv
rtl/core/mtd_checker.sv
verif/mtd_decoder_checker.sv
verif/tb_morse_tree_decoder_core.sv
